// ===== rtl/dow_pkg.sv =====
// Shared types, constants and calendar tables for the day-of-week pipeline.
package dow_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int WDAY_W  = 3;

   // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2**15.
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

   localparam int SUM_W = 16;
   localparam int FOLD_W = 6;

   // Day minus one plus the week offset of the calendar origin.
   localparam logic [SUM_W-1:0] DAY_BIAS = 16'd4;

   localparam logic [DAY_W-1:0] FEB_COMMON_DAYS = 5'd28;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [12:0]        q4;       // (year + 3) / 4
      logic [26:0]        p100y;    // year * RECIP_100
      logic [27:0]        p100;     // (year + 99) * RECIP_100
      logic [25:0]        p400;     // ((year + 399) / 4) * RECIP_100
   } stage_a_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             date_ok;
   } stage_b_type;

   typedef struct packed {
      logic [FOLD_W-1:0] fold;
      logic              date_ok;
   } stage_c_type;

   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [8:0] d;
      case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
      logic [DAY_W-1:0] d;
      case (m)
         4'd2:    d = FEB_COMMON_DAYS + DAY_W'(leap);
         4'd4:    d = 5'd30;
         4'd6:    d = 5'd30;
         4'd9:    d = 5'd30;
         4'd11:   d = 5'd30;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/dow_day_count.sv =====
// Leap year, date check and day count (mod 7 equivalent) from the scaled quotients.
module dow_day_count (
   input  dow_pkg::stage_a_type a_i,
   output dow_pkg::stage_b_type b_o
);
   import dow_pkg::*;

   logic [7:0]        q100y;
   logic [8:0]        q100;
   logic [6:0]        q400;
   logic [14:0]       q100y_times;
   logic              div100;
   logic              leap;
   logic              month_ok;
   logic              day_ok;
   logic [SUM_W-1:0]  sum;

   assign q100y = a_i.p100y[26:RECIP_SHIFT];
   assign q100  = a_i.p100[27:RECIP_SHIFT];
   assign q400  = a_i.p400[25:RECIP_SHIFT];

   assign q100y_times = 15'(q100y) * 15'd100;
   assign div100      = (q100y_times == 15'(a_i.year));

   // A century year is a leap year only when its century count is a multiple of four.
   assign leap = (a_i.year[1:0] == 2'b00) && (!div100 || (q100y[1:0] == 2'b00));

   assign month_ok = (a_i.month >= MONTH_JAN) && (a_i.month <= MONTH_DEC);
   assign day_ok   = (a_i.day != '0) && (a_i.day <= month_length(a_i.month, leap));

   // 365 is one more than a whole number of weeks, so the year itself stands for 365 * year.
   assign sum = SUM_W'(a_i.year) + SUM_W'(a_i.q4) - SUM_W'(q100) + SUM_W'(q400)
              + SUM_W'(days_before_month(a_i.month)) + SUM_W'(a_i.day)
              + SUM_W'(leap && (a_i.month > MONTH_FEB)) + DAY_BIAS;

   assign b_o.sum     = sum;
   assign b_o.date_ok = month_ok && day_ok;

endmodule

// ===== rtl/day_of_week_from_date_top.sv =====
// A request accepted into stage A passes through stages B and C and the output register to the rsp_ port.
// Throughput: one request per cycle unless rsp_ready back-pressure stalls it; four stages with per-stage valid bits.
// Each stage refills as soon as the stage behind it moves, so bubbles close up.
// The reciprocal multiplies in the first stage and the long sum in the second set the depth.
// Reset clears all stage valid bits; payload registers are not reset.
// No state is kept between requests.
module day_of_week_from_date_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [dow_pkg::DAY_W-1:0]   req_day_num,
   input  logic [dow_pkg::MONTH_W-1:0] req_month_num,
   input  logic [dow_pkg::YEAR_W-1:0]  req_year_num,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [dow_pkg::WDAY_W-1:0]  rsp_weekday,
   output logic                        rsp_date_valid
);
   import dow_pkg::*;

   logic        a_vld_ff, b_vld_ff, c_vld_ff, o_vld_ff;
   logic        a_rdy, b_rdy, c_rdy, o_rdy;
   stage_a_type a_in, a_ff;
   stage_b_type b_in, b_ff;
   stage_c_type c_in, c_ff;
   logic [WDAY_W-1:0] wday_in, wday_ff;
   logic              ok_ff;

   logic [14:0] y_p3, y_p99, y_p399;
   logic [17:0] sum_ext;
   logic [3:0]  fold2;

   // A stage may load when it is empty or its content moves on in the same cycle.
   assign o_rdy     = !o_vld_ff || rsp_ready;
   assign c_rdy     = !c_vld_ff || o_rdy;
   assign b_rdy     = !b_vld_ff || c_rdy;
   assign a_rdy     = !a_vld_ff || b_rdy;
   assign req_ready = a_rdy;

   // Stage A: form (year + 3) / 4 and scale the year and the shifted years by the reciprocal of 100.
   always_comb begin
      y_p3         = 15'(req_year_num) + 15'd3;
      y_p99        = 15'(req_year_num) + 15'd99;
      y_p399       = 15'(req_year_num) + 15'd399;
      a_in.day     = req_day_num;
      a_in.month   = req_month_num;
      a_in.year    = req_year_num;
      a_in.q4      = y_p3[14:2];
      a_in.p100y   = 27'(req_year_num) * 27'(RECIP_100);
      a_in.p100    = 28'(y_p99) * 28'(RECIP_100);
      a_in.p400    = 26'(y_p399[14:2]) * 26'(RECIP_100);
   end

   // Stage B: day count whose residue mod 7 is the weekday, and the date check.
   dow_day_count u_day_count (
      .a_i (a_ff),
      .b_o (b_in)
   );

   // Stage C: eight is one more than seven, so summing octal digits keeps the residue.
   always_comb begin
      sum_ext      = 18'(b_ff.sum);
      c_in.fold    = FOLD_W'(sum_ext[2:0]) + FOLD_W'(sum_ext[5:3]) + FOLD_W'(sum_ext[8:6])
                   + FOLD_W'(sum_ext[11:9]) + FOLD_W'(sum_ext[14:12])
                   + FOLD_W'(sum_ext[17:15]);
      c_in.date_ok = b_ff.date_ok;
   end

   // Output stage: final fold and a correction down to 0..6; an invalid date gives 0.
   always_comb begin
      fold2 = 4'(c_ff.fold[2:0]) + 4'(c_ff.fold[5:3]);
      if (!c_ff.date_ok) begin
         wday_in = '0;
      end else if (fold2 >= 4'd14) begin
         wday_in = WDAY_W'(fold2 - 4'd14);
      end else if (fold2 >= 4'd7) begin
         wday_in = WDAY_W'(fold2 - 4'd7);
      end else begin
         wday_in = WDAY_W'(fold2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         if (a_rdy) a_vld_ff <= req_valid;
         if (b_rdy) b_vld_ff <= a_vld_ff;
         if (c_rdy) c_vld_ff <= b_vld_ff;
         if (o_rdy) o_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_rdy) a_ff <= a_in;
      if (b_rdy) b_ff <= b_in;
      if (c_rdy) c_ff <= c_in;
      if (o_rdy) begin
         wday_ff <= wday_in;
         ok_ff   <= c_ff.date_ok;
      end
   end

   assign rsp_valid      = o_vld_ff;
   assign rsp_weekday    = wday_ff;
   assign rsp_date_valid = ok_ff;

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (o_vld_ff && !ok_ff) |-> (wday_ff == '0))
      else $error("invalid date produced a nonzero weekday");

   a_weekday_range : assert property (@(posedge clock) disable iff (reset)
      o_vld_ff |-> (wday_ff <= WDAY_W'(6)))
      else $error("weekday out of range");

   a_stall_holds_b : assert property (@(posedge clock) disable iff (reset)
      (b_vld_ff && !c_rdy) |=> (b_vld_ff && $stable(b_ff)))
      else $error("stalled stage B lost its request");

   a_stall_holds_c : assert property (@(posedge clock) disable iff (reset)
      (c_vld_ff && !o_rdy) |=> (c_vld_ff && $stable(c_ff)))
      else $error("stalled stage C lost its request");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!a_vld_ff && !b_vld_ff && !c_vld_ff && !o_vld_ff))
      else $error("pipeline not empty after reset");

endmodule
